// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/nlut_pkg.sv =====
package nlut_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 14;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned AXIS_W = 8;   // index on one axis, sizes up to 256
  localparam int unsigned CFG_AW = 5;   // eight 32-bit registers

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [2:0] REG_MIN_COS        = 3'd0;
  localparam logic [2:0] REG_MIN_ROUGH      = 3'd1;
  localparam logic [2:0] REG_MIN_IOR_REAL   = 3'd2;
  localparam logic [2:0] REG_MIN_IOR_IMAG   = 3'd3;
  localparam logic [2:0] REG_SCALE_COS      = 3'd4;
  localparam logic [2:0] REG_SCALE_ROUGH    = 3'd5;
  localparam logic [2:0] REG_SCALE_IOR_REAL = 3'd6;
  localparam logic [2:0] REG_SCALE_IOR_IMAG = 3'd7;

  localparam logic [DATA_W-1:0] RST_MIN_COS        = 32'd0;
  localparam logic [DATA_W-1:0] RST_MIN_ROUGH      = 32'd0;
  localparam logic [DATA_W-1:0] RST_MIN_IOR_REAL   = 32'd65536;
  localparam logic [DATA_W-1:0] RST_MIN_IOR_IMAG   = 32'd0;
  localparam logic [DATA_W-1:0] RST_SCALE_COS      = 32'd983040;
  localparam logic [DATA_W-1:0] RST_SCALE_ROUGH    = 32'd983040;
  localparam logic [DATA_W-1:0] RST_SCALE_IOR_REAL = 32'd458752;
  localparam logic [DATA_W-1:0] RST_SCALE_IOR_IMAG = 32'd458752;

  // Load enables of the three index stages.
  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
  } adv_t;

  // One beat presented to the table memory.
  typedef struct packed {
    logic              valid;
    logic              write;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } req_t;

endpackage

// ===== src/nlut_axis.sv =====
module nlut_axis #(
  parameter int SIZE = 16
) (
  input  logic                        clk_i,
  input  nlut_pkg::adv_t              adv_i,
  input  logic [nlut_pkg::DATA_W-1:0] coord_i,
  input  logic [nlut_pkg::DATA_W-1:0] min_i,
  input  logic [nlut_pkg::DATA_W-1:0] scale_i,
  output logic [nlut_pkg::AXIS_W-1:0] idx_o
);

  localparam logic [31:0] LIMIT = 32'(SIZE - 1);
  localparam logic [nlut_pkg::AXIS_W-1:0] IDX_MAX = nlut_pkg::AXIS_W'(SIZE - 1);

  logic [32:0]                 diff;
  logic                        diff_pos;
  logic [31:0]                 diff_q;
  logic [63:0]                 prod_q;
  logic                        sat;
  logic [nlut_pkg::AXIS_W-1:0] rnd;
  logic [nlut_pkg::AXIS_W-1:0] idx_q;

  // Non-positive offsets land on index 0; a positive one fits 32 bits.
  assign diff     = {coord_i[31], coord_i} - {min_i[31], min_i};
  assign diff_pos = !diff[32] && (diff[31:0] != 32'd0);

  // Integer part at or above size-1 saturates; otherwise round half up.
  assign sat = prod_q[63:32] >= LIMIT;
  assign rnd = prod_q[32 +: nlut_pkg::AXIS_W] + nlut_pkg::AXIS_W'(prod_q[31]);

  always_ff @(posedge clk_i) begin
    if (adv_i.en_a) begin
      diff_q <= diff_pos ? diff[31:0] : 32'd0;
    end
    if (adv_i.en_b) begin
      prod_q <= 64'(diff_q) * 64'(scale_i);
    end
    if (adv_i.en_c) begin
      idx_q <= sat ? IDX_MAX : rnd;
    end
  end

  assign idx_o = idx_q;

endmodule

// ===== src/nlut_store.sv =====
module nlut_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nlut_pkg::req_t              req_i,
  input  logic                        out_ready_i,
  output logic                        ready_o,
  output logic [nlut_pkg::DATA_W-1:0] rdata_o,
  output logic                        rvalid_o
);

  logic [nlut_pkg::DATA_W-1:0] mem [nlut_pkg::DEPTH];
  logic [nlut_pkg::DATA_W-1:0] rdata_q;
  logic                        rvalid_q;
  logic                        rvalid_d;

  // Take a new beat once the held result is gone or leaves this cycle.
  assign ready_o  = !rvalid_q || out_ready_i;
  assign rvalid_d = ready_o ? (req_i.valid && (req_i.write == nlut_pkg::OP_LOOKUP))
                            : rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ready_o && req_i.valid) begin
      if (req_i.write == nlut_pkg::OP_WRITE) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rvalid_d;
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

// ===== src/nearest_4d_table_lookup.sv =====
// Nearest-grid-point lookup in a four-dimensional table of 32-bit words held in
// one 16384-word single-port memory. A write beat (opcode 1) stores write_word_i
// at write_addr_i and returns nothing; a lookup beat (opcode 0) returns exactly
// one table_word_o beat. For each axis the lookup forms (coordinate - min) *
// scale exactly in Q32.32, clamps to [0, size-1], rounds half up and combines
// the four indices row-major (cosine outermost, extinction innermost); a flat
// index beyond the memory keeps its low 14 bits. The table needs no clearing
// after reset, but a lookup must only touch entries written since reset.
// Throughput is one beat per cycle while the output is not stalled; each lookup
// beat is registered at offset, 32x32 multiply, clamp and round, flat address
// and memory read into the output register. Writes and reads share the memory
// port at the same stage in beat order, so a lookup always sees every earlier
// write. Stages fill bubbles independently, so input beats keep flowing while a
// result waits at the output. Configure the eight registers over the APB port
// (byte address 4*index, pready always high) only while the block is idle.
module nearest_4d_table_lookup #(
  parameter int COS_SIZE      = 16,
  parameter int ROUGH_SIZE    = 16,
  parameter int IOR_REAL_SIZE = 8,
  parameter int IOR_IMAG_SIZE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlut_pkg::CFG_AW-1:0]   paddr,
  input  logic [nlut_pkg::DATA_W-1:0]   pwdata,
  output logic [nlut_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic signed [31:0]            cos_in_i,
  input  logic signed [31:0]            rough_in_i,
  input  logic signed [31:0]            ior_real_in_i,
  input  logic signed [31:0]            ior_imag_in_i,
  input  logic [nlut_pkg::ADDR_W-1:0]   write_addr_i,
  input  logic [nlut_pkg::DATA_W-1:0]   write_word_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nlut_pkg::DATA_W-1:0]   table_word_o
);

  localparam logic [nlut_pkg::ADDR_W-1:0] RS_W = nlut_pkg::ADDR_W'(ROUGH_SIZE);
  localparam logic [nlut_pkg::ADDR_W-1:0] RR_W = nlut_pkg::ADDR_W'(IOR_REAL_SIZE);
  localparam logic [nlut_pkg::ADDR_W-1:0] RI_W = nlut_pkg::ADDR_W'(IOR_IMAG_SIZE);

  // configuration registers
  logic [31:0] min_cos_q, min_rough_q, min_ior_real_q, min_ior_imag_q;
  logic [31:0] scale_cos_q, scale_rough_q, scale_ior_real_q, scale_ior_imag_q;
  logic        cfg_we;

  // stage valids (control) and side payloads (write beats ride along)
  logic v_a_q, v_b_q, v_c_q, v_d_q;
  logic op_a_q, op_b_q, op_c_q, op_d_q;
  logic [nlut_pkg::ADDR_W-1:0] waddr_a_q, waddr_b_q, waddr_c_q, addr_d_q;
  logic [nlut_pkg::DATA_W-1:0] wword_a_q, wword_b_q, wword_c_q, wdata_d_q;

  logic                        en_d, st_ready;
  nlut_pkg::adv_t              adv;
  nlut_pkg::req_t              req;
  logic [nlut_pkg::AXIS_W-1:0] idx_cos, idx_rough, idx_real, idx_imag;
  logic [nlut_pkg::ADDR_W-1:0] flat_0, flat_1, flat_2;

  // ---------------------------------------------------------------------
  // APB register file: write on the access phase, read back combinationally.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cos_q        <= nlut_pkg::RST_MIN_COS;
      min_rough_q      <= nlut_pkg::RST_MIN_ROUGH;
      min_ior_real_q   <= nlut_pkg::RST_MIN_IOR_REAL;
      min_ior_imag_q   <= nlut_pkg::RST_MIN_IOR_IMAG;
      scale_cos_q      <= nlut_pkg::RST_SCALE_COS;
      scale_rough_q    <= nlut_pkg::RST_SCALE_ROUGH;
      scale_ior_real_q <= nlut_pkg::RST_SCALE_IOR_REAL;
      scale_ior_imag_q <= nlut_pkg::RST_SCALE_IOR_IMAG;
    end else if (cfg_we) begin
      case (paddr[4:2])
        nlut_pkg::REG_MIN_COS:        min_cos_q        <= pwdata;
        nlut_pkg::REG_MIN_ROUGH:      min_rough_q      <= pwdata;
        nlut_pkg::REG_MIN_IOR_REAL:   min_ior_real_q   <= pwdata;
        nlut_pkg::REG_MIN_IOR_IMAG:   min_ior_imag_q   <= pwdata;
        nlut_pkg::REG_SCALE_COS:      scale_cos_q      <= pwdata;
        nlut_pkg::REG_SCALE_ROUGH:    scale_rough_q    <= pwdata;
        nlut_pkg::REG_SCALE_IOR_REAL: scale_ior_real_q <= pwdata;
        nlut_pkg::REG_SCALE_IOR_IMAG: scale_ior_imag_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      nlut_pkg::REG_MIN_COS:        prdata = min_cos_q;
      nlut_pkg::REG_MIN_ROUGH:      prdata = min_rough_q;
      nlut_pkg::REG_MIN_IOR_REAL:   prdata = min_ior_real_q;
      nlut_pkg::REG_MIN_IOR_IMAG:   prdata = min_ior_imag_q;
      nlut_pkg::REG_SCALE_COS:      prdata = scale_cos_q;
      nlut_pkg::REG_SCALE_ROUGH:    prdata = scale_rough_q;
      nlut_pkg::REG_SCALE_IOR_REAL: prdata = scale_ior_real_q;
      nlut_pkg::REG_SCALE_IOR_IMAG: prdata = scale_ior_imag_q;
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: each stage loads when it is empty or its successor loads.
  // Bubbles collapse, so the input side keeps moving while a result waits.
  // ---------------------------------------------------------------------
  assign en_d     = !v_d_q || st_ready;
  assign adv.en_c = !v_c_q || en_d;
  assign adv.en_b = !v_b_q || adv.en_c;
  assign adv.en_a = !v_a_q || adv.en_b;
  assign in_ready_o = adv.en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      if (adv.en_a) v_a_q <= in_valid_i;
      if (adv.en_b) v_b_q <= v_a_q;
      if (adv.en_c) v_c_q <= v_b_q;
      if (en_d)     v_d_q <= v_c_q;
    end
  end

  // Carry opcode and write payload alongside the index lanes.
  always_ff @(posedge clk_i) begin
    if (adv.en_a) begin
      op_a_q    <= opcode_i;
      waddr_a_q <= write_addr_i;
      wword_a_q <= write_word_i;
    end
    if (adv.en_b) begin
      op_b_q    <= op_a_q;
      waddr_b_q <= waddr_a_q;
      wword_b_q <= wword_a_q;
    end
    if (adv.en_c) begin
      op_c_q    <= op_b_q;
      waddr_c_q <= waddr_b_q;
      wword_c_q <= wword_b_q;
    end
    if (en_d) begin
      op_d_q    <= op_c_q;
      addr_d_q  <= (op_c_q == nlut_pkg::OP_WRITE) ? waddr_c_q : flat_2;
      wdata_d_q <= wword_c_q;
    end
  end

  // ---------------------------------------------------------------------
  // Per-axis index lanes: offset, exact product, clamp and round.
  // ---------------------------------------------------------------------
  nlut_axis #(.SIZE(COS_SIZE)) u_axis_cos (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .coord_i (cos_in_i),
    .min_i   (min_cos_q),
    .scale_i (scale_cos_q),
    .idx_o   (idx_cos)
  );

  nlut_axis #(.SIZE(ROUGH_SIZE)) u_axis_rough (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .coord_i (rough_in_i),
    .min_i   (min_rough_q),
    .scale_i (scale_rough_q),
    .idx_o   (idx_rough)
  );

  nlut_axis #(.SIZE(IOR_REAL_SIZE)) u_axis_real (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .coord_i (ior_real_in_i),
    .min_i   (min_ior_real_q),
    .scale_i (scale_ior_real_q),
    .idx_o   (idx_real)
  );

  nlut_axis #(.SIZE(IOR_IMAG_SIZE)) u_axis_imag (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .coord_i (ior_imag_in_i),
    .min_i   (min_ior_imag_q),
    .scale_i (scale_ior_imag_q),
    .idx_o   (idx_imag)
  );

  // Row-major flat index, kept modulo the memory depth.
  assign flat_0 = nlut_pkg::ADDR_W'(idx_cos) * RS_W + nlut_pkg::ADDR_W'(idx_rough);
  assign flat_1 = flat_0 * RR_W + nlut_pkg::ADDR_W'(idx_real);
  assign flat_2 = flat_1 * RI_W + nlut_pkg::ADDR_W'(idx_imag);

  // ---------------------------------------------------------------------
  // Table memory and output register.
  // ---------------------------------------------------------------------
  assign req.valid = v_d_q;
  assign req.write = op_d_q;
  assign req.addr  = addr_d_q;
  assign req.wdata = wdata_d_q;

  nlut_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .out_ready_i (out_ready_i),
    .ready_o     (st_ready),
    .rdata_o     (table_word_o),
    .rvalid_o    (out_valid_o)
  );

endmodule

// ===== src/nlut_checker.sv =====
`include "assert_macros.svh"

module nlut_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] table_word_o
);

  // A stalled result holds its valid and its word.
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(table_word_o), "result dropped or changed while stalled")

  // Reset empties the output register by the next edge.
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_o, "result valid after reset")

  // With the output free to drain, every stage can move, so input is open.
  `CHK_ASSERT(a_flow, clk_i, rst_ni, (!out_valid_o || out_ready_i) |-> in_ready_o, "input stalled with a free output")

  // The register port never inserts wait states.
  `CHK_ASSERT(a_pready, clk_i, rst_ni, pready, "pready low")

endmodule

bind nearest_4d_table_lookup nlut_checker u_nlut_checker (.*);
